// ===== rtl/crb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package crb_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIM_W      = 13;
    localparam int INDEX_W    = 24;
    localparam int COLOUR_W   = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_LEFT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_TOP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOUR   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_MODE     = 3'd7;

    // values after reset
    localparam logic [DIM_W-1:0] RST_SCREEN_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0] RST_SCREEN_HEIGHT = 13'd480;
    localparam logic [DIM_W-1:0] RST_RECT_LEFT     = 13'd0;
    localparam logic [DIM_W-1:0] RST_RECT_TOP      = 13'd0;
    localparam logic [DIM_W-1:0] RST_RECT_WIDTH    = 13'd1;
    localparam logic [DIM_W-1:0] RST_RECT_HEIGHT   = 13'd1;
    localparam logic [COLOUR_W-1:0] RST_FILL_COLOUR = 32'd0;
    localparam logic RST_FILL_MODE = 1'b0;

    typedef struct packed {
        logic [DIM_W-1:0]    screen_width;
        logic [DIM_W-1:0]    screen_height;
        logic [DIM_W-1:0]    rect_left;
        logic [DIM_W-1:0]    rect_top;
        logic [DIM_W-1:0]    rect_width;
        logic [DIM_W-1:0]    rect_height;
        logic [COLOUR_W-1:0] fill_colour;
        logic                fill_mode;
    } cfg_t;

    typedef struct packed {
        logic                write_enable;
        logic [INDEX_W-1:0]  pixel_index;
        logic [COLOUR_W-1:0] pixel_colour;
        logic                last;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/crb_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crb_cfg_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [crb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [crb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output crb_pkg::cfg_t                      cfg
);
    import crb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_wdata[DIM_W-1:0];
                REG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_wdata[DIM_W-1:0];
                REG_RECT_LEFT:     cfg_next.rect_left     = cfg_wdata[DIM_W-1:0];
                REG_RECT_TOP:      cfg_next.rect_top      = cfg_wdata[DIM_W-1:0];
                REG_RECT_WIDTH:    cfg_next.rect_width    = cfg_wdata[DIM_W-1:0];
                REG_RECT_HEIGHT:   cfg_next.rect_height   = cfg_wdata[DIM_W-1:0];
                REG_FILL_COLOUR:   cfg_next.fill_colour   = cfg_wdata[COLOUR_W-1:0];
                REG_FILL_MODE:     cfg_next.fill_mode     = cfg_wdata[0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.screen_width  <= RST_SCREEN_WIDTH;
            cfg_reg.screen_height <= RST_SCREEN_HEIGHT;
            cfg_reg.rect_left     <= RST_RECT_LEFT;
            cfg_reg.rect_top      <= RST_RECT_TOP;
            cfg_reg.rect_width    <= RST_RECT_WIDTH;
            cfg_reg.rect_height   <= RST_RECT_HEIGHT;
            cfg_reg.fill_colour   <= RST_FILL_COLOUR;
            cfg_reg.fill_mode     <= RST_FILL_MODE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/crb_pixel_calc.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crb_pixel_calc #(
    parameter int MAX_DIM = 4096,
    parameter int CNT_W   = 12
) (
    input  crb_pkg::cfg_t                      cfg,
    input  wire logic [CNT_W-1:0]              column_count,
    input  wire logic [CNT_W-1:0]              row_count,
    input  wire logic [crb_pkg::COLOUR_W-1:0]  source_pixel,
    output crb_pkg::result_t                   result,
    output logic [CNT_W-1:0]                   column_next,
    output logic [CNT_W-1:0]                   row_next
);
    import crb_pkg::*;

    // signed screen position: 13-bit edge plus counter, one bit of headroom
    localparam int POS_W = ((CNT_W > DIM_W - 1) ? CNT_W : DIM_W - 1) + 2;
    // rectangle size compare width, must hold MAX_DIM and any register value
    localparam int SZ_W  = (CNT_W + 1 > DIM_W) ? CNT_W + 1 : DIM_W;
    localparam int PROD_W = 2 * DIM_W;

    logic signed [POS_W-1:0] sx;
    logic signed [POS_W-1:0] sy;
    logic [POS_W-1:0]        scr_w_ext;
    logic [POS_W-1:0]        scr_h_ext;
    logic                    on_screen;
    logic [SZ_W-1:0]         rect_w;
    logic [SZ_W-1:0]         rect_h;
    logic [SZ_W-1:0]         col_plus1;
    logic [SZ_W-1:0]         row_plus1;
    logic                    col_end;
    logic                    row_end;
    logic [PROD_W-1:0]       prod;
    logic [PROD_W-1:0]       lin;

    function automatic logic [SZ_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [SZ_W-1:0] ext;
        ext = SZ_W'(v);
        if (ext == '0)
            return SZ_W'(1);
        else if (ext > SZ_W'(MAX_DIM))
            return SZ_W'(MAX_DIM);
        else
            return ext;
    endfunction

    always_comb begin
        sx = $signed({{(POS_W-DIM_W){cfg.rect_left[DIM_W-1]}}, cfg.rect_left})
           + $signed({{(POS_W-CNT_W){1'b0}}, column_count});
        sy = $signed({{(POS_W-DIM_W){cfg.rect_top[DIM_W-1]}}, cfg.rect_top})
           + $signed({{(POS_W-CNT_W){1'b0}}, row_count});
        scr_w_ext = POS_W'(cfg.screen_width);
        scr_h_ext = POS_W'(cfg.screen_height);
        on_screen = !sx[POS_W-1] && !sy[POS_W-1]
                 && (POS_W'(sx) < scr_w_ext) && (POS_W'(sy) < scr_h_ext);

        // on screen implies both coordinates fit in 13 bits
        prod = PROD_W'(sy[DIM_W-1:0]) * PROD_W'(cfg.screen_width);
        lin  = prod + PROD_W'(sx[DIM_W-1:0]);

        rect_w    = clamp_dim(cfg.rect_width);
        rect_h    = clamp_dim(cfg.rect_height);
        col_plus1 = SZ_W'(column_count) + SZ_W'(1);
        row_plus1 = SZ_W'(row_count) + SZ_W'(1);
        col_end   = col_plus1 >= rect_w;
        row_end   = row_plus1 >= rect_h;

        result.write_enable = on_screen;
        result.pixel_index  = on_screen ? lin[INDEX_W-1:0] : '0;
        result.pixel_colour = !on_screen   ? '0 :
                              cfg.fill_mode ? cfg.fill_colour : source_pixel;
        result.last         = col_end && row_end;

        if (col_end) begin
            column_next = '0;
            row_next    = row_end ? '0 : row_plus1[CNT_W-1:0];
        end else begin
            column_next = col_plus1[CNT_W-1:0];
            row_next    = row_count;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/clipped_rect_blit_address_gen.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Address generator for a clipped rectangle blit.
// Configuration: write cfg_we with cfg_index/cfg_wdata while the block is idle;
// registers set the screen size, the rectangle position and size, fill colour
// and copy/fill mode.
// Input channel (s_): one source pixel per item, in raster order over the
// rectangle. Output channel (m_): one item per input item carrying the write
// enable, the linear framebuffer index, the colour and the last-pixel flag.
// Clipped pixels come out with write enable low and zero index and colour.
// Accepted items are registered in the result register, or in the skid register
// on a stall; one item per clock unless m_ready stalls; a single multiply.
// A two-entry output stage (result register plus skid register) keeps s_ready
// a register output; a stalled receiver holds at most two items before the
// input is back-pressured.
// Reset clears the column and row counters and the output stage, and loads the
// configuration defaults (640x480 screen, 1x1 rectangle at the origin, copy).
module clipped_rect_blit_address_gen #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [crb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [crb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [crb_pkg::COLOUR_W-1:0]     s_source_pixel,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_write_enable,
    output logic [crb_pkg::INDEX_W-1:0]           m_pixel_index,
    output logic [crb_pkg::COLOUR_W-1:0]          m_pixel_colour,
    output logic                                  m_last
);
    import crb_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIM);

    cfg_t             cfg;
    result_t          result;
    logic [CNT_W-1:0] column_reg;
    logic [CNT_W-1:0] row_reg;
    logic [CNT_W-1:0] column_next;
    logic [CNT_W-1:0] row_next;
    result_t          out_reg;
    result_t          skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic             accept;
    logic             out_free;

    crb_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    crb_pixel_calc #(
        .MAX_DIM (MAX_DIM),
        .CNT_W   (CNT_W)
    ) u_calc (
        .cfg          (cfg),
        .column_count (column_reg),
        .row_count    (row_reg),
        .source_pixel (s_source_pixel),
        .result       (result),
        .column_next  (column_next),
        .row_next     (row_next)
    );

    assign s_ready  = !skid_valid_reg;
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            row_reg    <= '0;
        end else if (accept) begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            // skid holds the older item, so it drains first
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= result;
        end else if (accept) begin
            skid_reg <= result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_write_enable = out_reg.write_enable;
    assign m_pixel_index  = out_reg.pixel_index;
    assign m_pixel_colour = out_reg.pixel_colour;
    assign m_last         = out_reg.last;

endmodule

`default_nettype wire

// ===== tb/clipped_rect_blit_address_gen_tb.sv =====
`timescale 1ns / 1ps

module clipped_rect_blit_address_gen_tb;

    import crb_pkg::*;

    localparam int MAX_DIM   = 4096;
    localparam int LONG_HOLD = 300;
    localparam int DRAIN_GAP = 4;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [COLOUR_W-1:0]   s_source_pixel = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_write_enable;
    logic [INDEX_W-1:0]    m_pixel_index;
    logic [COLOUR_W-1:0]   m_pixel_colour;
    logic                  m_last;

    logic [COLOUR_W-1:0] source_pixels[$];
    result_t             pending_writes[$];

    cfg_t        shadow_cfg;
    logic [11:0] col_pos = '0;
    logic [11:0] row_pos = '0;

    int unsigned tx_idle_pct = 17;
    int unsigned rx_idle_pct = 76;
    logic        hold_req = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;
    int          mismatch_count = 0;

    clipped_rect_blit_address_gen #(
        .MAX_DIM(MAX_DIM)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_source_pixel(s_source_pixel),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_write_enable(m_write_enable),
        .m_pixel_index (m_pixel_index),
        .m_pixel_colour(m_pixel_colour),
        .m_last        (m_last)
    );

    always #1 aclk = ~aclk;

    function automatic int clamp_dim(input logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    // works out the write for one source pixel and steps the raster counters
    function automatic result_t predict_pixel_write(input logic [COLOUR_W-1:0] src);
        int          w;
        int          h;
        int          sx;
        int          sy;
        logic        on;
        logic        col_end;
        logic        row_end;
        logic [31:0] lin;
        result_t     r;
        w = clamp_dim(shadow_cfg.rect_width);
        h = clamp_dim(shadow_cfg.rect_height);
        sx = $signed(shadow_cfg.rect_left);
        sy = $signed(shadow_cfg.rect_top);
        sx = sx + int'(col_pos);
        sy = sy + int'(row_pos);
        on = sx >= 0 && sy >= 0 && sx < int'(shadow_cfg.screen_width)
             && sy < int'(shadow_cfg.screen_height);
        col_end = int'(col_pos) + 1 >= w;
        row_end = int'(row_pos) + 1 >= h;
        lin = sy * int'(shadow_cfg.screen_width) + sx;
        r.write_enable = on;
        r.pixel_index  = on ? lin[INDEX_W-1:0] : '0;
        r.pixel_colour = !on ? '0 : (shadow_cfg.fill_mode ? shadow_cfg.fill_colour : src);
        r.last         = col_end && row_end;
        if (col_end) begin
            col_pos = '0;
            row_pos = row_end ? 12'd0 : row_pos + 12'd1;
        end else begin
            col_pos = col_pos + 12'd1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pending_writes.push_back(predict_pixel_write(s_source_pixel));
            end
            if (!s_valid || s_ready) begin
                if (source_pixels.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_valid        <= 1'b1;
                    s_source_pixel <= source_pixels.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with an occasional long hold-off to back the block up
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= $urandom_range(99) >= rx_idle_pct;
        end
    end

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_writes.size() == 0) begin
                report_mismatch($sformatf("item with none expected: we=%0b idx=%h col=%h last=%0b",
                                          m_write_enable, m_pixel_index, m_pixel_colour, m_last));
            end else begin
                want = pending_writes.pop_front();
                if (m_write_enable !== want.write_enable)
                    report_mismatch($sformatf("write_enable %0b, want %0b",
                                              m_write_enable, want.write_enable));
                if (m_pixel_index !== want.pixel_index)
                    report_mismatch($sformatf("pixel_index %h, want %h",
                                              m_pixel_index, want.pixel_index));
                if (m_pixel_colour !== want.pixel_colour)
                    report_mismatch($sformatf("pixel_colour %h, want %h",
                                              m_pixel_colour, want.pixel_colour));
                if (m_last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", m_last, want.last));
            end
        end
    end

    task automatic wait_drained();
        @(negedge aclk);
        while (source_pixels.size() != 0 || s_valid || pending_writes.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
    endtask

    // upper bits of the narrow registers carry noise, which the block drops
    task automatic load_cfg(input cfg_t c);
        logic [31:0] wd;
        wd = $urandom; wd[DIM_W-1:0] = c.screen_width;  write_reg(REG_SCREEN_WIDTH, wd);
        wd = $urandom; wd[DIM_W-1:0] = c.screen_height; write_reg(REG_SCREEN_HEIGHT, wd);
        wd = $urandom; wd[DIM_W-1:0] = c.rect_left;     write_reg(REG_RECT_LEFT, wd);
        wd = $urandom; wd[DIM_W-1:0] = c.rect_top;      write_reg(REG_RECT_TOP, wd);
        wd = $urandom; wd[DIM_W-1:0] = c.rect_width;    write_reg(REG_RECT_WIDTH, wd);
        wd = $urandom; wd[DIM_W-1:0] = c.rect_height;   write_reg(REG_RECT_HEIGHT, wd);
        write_reg(REG_FILL_COLOUR, c.fill_colour);
        wd = $urandom; wd[0] = c.fill_mode;             write_reg(REG_FILL_MODE, wd);
        @(posedge aclk);
        cfg_we     <= 1'b0;
        shadow_cfg = c;
    endtask

    task automatic queue_random_pixels(input int n);
        @(negedge aclk);
        repeat (n) source_pixels.push_back($urandom);
    endtask

    function automatic logic [DIM_W-1:0] pick_screen_dim();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 13'd8191;
            2:       return 13'($urandom_range(4096, 8190));
            default: return 13'($urandom_range(1, 48));
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_offset();
        if ($urandom_range(7) == 0) return 13'($urandom);
        return 13'($urandom_range(0, 80) - 20);
    endfunction

    function automatic logic [DIM_W-1:0] pick_rect_dim();
        case ($urandom_range(15))
            0:       return '0;
            1:       return 13'($urandom_range(4097, 8191));
            2:       return 13'd4096;
            default: return 13'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic cfg_t pick_cfg();
        cfg_t c;
        c.screen_width  = pick_screen_dim();
        c.screen_height = pick_screen_dim();
        c.rect_left     = pick_offset();
        c.rect_top      = pick_offset();
        c.rect_width    = pick_rect_dim();
        c.rect_height   = pick_rect_dim();
        c.fill_colour   = $urandom;
        c.fill_mode     = 1'($urandom_range(1));
        return c;
    endfunction

    initial begin
        int regime_items;
        int n;
        shadow_cfg = '{RST_SCREEN_WIDTH, RST_SCREEN_HEIGHT, RST_RECT_LEFT, RST_RECT_TOP,
                       RST_RECT_WIDTH, RST_RECT_HEIGHT, RST_FILL_COLOUR, RST_FILL_MODE};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // defaults after reset: 1x1 rectangle at the origin, copy
        @(negedge aclk);
        source_pixels.push_back(32'h0000_0000);
        source_pixels.push_back(32'hFFFF_FFFF);
        source_pixels.push_back(32'hA5A5_A5A5);

        // rectangle hanging off the top and left edges, fill colour
        wait_drained();
        load_cfg('{13'd3, 13'd2, -13'sd2, -13'sd1, 13'd4, 13'd3, 32'hDEAD_BEEF, 1'b1});
        queue_random_pixels(12);

        // widest screen and far corner: index truncated to 24 bits, zero-size rectangle
        wait_drained();
        load_cfg('{13'd8191, 13'd8191, 13'd4095, 13'd4095, 13'd0, 13'd0,
                   32'h0000_0000, 1'b0});
        @(negedge aclk);
        source_pixels.push_back(32'hFFFF_FFFF);
        source_pixels.push_back(32'h5A5A_5A5A);

        // zero-width screen, oversize rectangle at the far left
        wait_drained();
        load_cfg('{13'd0, 13'd8191, -13'sd4096, 13'd0, 13'd5000, 13'd8191,
                   32'hFFFF_FFFF, 1'b1});
        queue_random_pixels(3);

        for (int regime = 0; regime < 3; regime++) begin
            @(posedge aclk);
            case (regime)
                0: begin tx_idle_pct <= 17; rx_idle_pct <= 76; end
                1: begin tx_idle_pct <= 76; rx_idle_pct <= 17; end
                default: begin tx_idle_pct <= 0; rx_idle_pct <= 0; end
            endcase
            regime_items = 0;
            while (regime_items < 365) begin
                wait_drained();
                load_cfg(pick_cfg());
                n = $urandom_range(20, 60);
                if (regime == 2 && regime_items == 0) begin
                    // receiver goes quiet while the sender keeps pushing
                    @(posedge aclk);
                    hold_req <= ~hold_req;
                    n = 80;
                end
                queue_random_pixels(n);
                regime_items += n;
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("clipped_rect_blit_address_gen_tb: done, clean");
        end else begin
            $display("clipped_rect_blit_address_gen_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #400_000;
        $display("clipped_rect_blit_address_gen_tb: done, errors");
        $finish;
    end

endmodule

// ===== clipped_rect_blit_address_gen.f =====
rtl/crb_pkg.sv
rtl/crb_cfg_regs.sv
rtl/crb_pixel_calc.sv
rtl/clipped_rect_blit_address_gen.sv
tb/clipped_rect_blit_address_gen_tb.sv
